// ===== rtl/bsq_pkg.sv =====
// Package for the bounded stable priority queue.
// Holds operation and status codes, field widths and the controller command type.
// No dependencies.
package bsq_pkg;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 16;
    localparam int AMT_W    = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 48;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // operation codes carried in the input tuser
    localparam logic [KIND_W-1:0] KIND_ENQ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic load;   // capture the accepted transaction
        logic exec;   // run the captured operation and load the result
    } t_ctl_cmd;

endpackage

// ===== rtl/bsq_ctrl.sv =====
// Controller of the bounded stable priority queue: handshake state machine.
// Depends on bsq_pkg for the command type.
module bsq_ctrl
    import bsq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ctl_cmd o_cmd
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold the operation until the result register can take it
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/bsq_datapath.sv =====
// Datapath of the bounded stable priority queue: sorted cell chain, counters,
// running total and result register. Depends on bsq_pkg.
module bsq_datapath
    import bsq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctl_cmd                   i_cmd,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic [ID_W-1:0]            i_customer_id,
    input  logic [AMT_W-1:0]           i_amount_cents,
    input  logic signed [PRIO_W-1:0]   i_priority_req,
    input  logic                       i_cfg_wr_en,
    input  logic [CAP_W-1:0]           i_cfg_wr_data,
    output logic [STATUS_W-1:0]        o_status,
    output logic [ID_W-1:0]            o_served_id,
    output logic [AMT_W-1:0]           o_served_amount,
    output logic [TOTAL_W-1:0]         o_running_total,
    output logic [COUNT_W-1:0]         o_entry_count,
    output logic                       o_is_open
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    // captured operation
    logic [KIND_W-1:0]        r_kind;
    logic [ID_W-1:0]          r_id_in;
    logic [AMT_W-1:0]         r_amt_in;
    logic signed [PRIO_W-1:0] r_prio_in;

    // cell chain, head in cell 0
    logic [ID_W-1:0]          r_cell_id   [DEPTH];
    logic [AMT_W-1:0]         r_cell_amt  [DEPTH];
    logic signed [PRIO_W-1:0] r_cell_prio [DEPTH];

    logic [CW-1:0]      r_held, n_held;
    logic               r_open, n_open;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CAP_W-1:0]   r_cap;

    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_W-1:0]     r_srv_id, n_srv_id;
    logic [AMT_W-1:0]    r_srv_amt, n_srv_amt;

    logic               full, enq_do, deq_do;
    logic [TOTAL_W:0]   sum;
    logic [DEPTH-1:0]   ge;

    assign full = ({{(EW-CW){1'b0}}, r_held} >= {{(EW-CAP_W){1'b0}}, r_cap})
               || (r_held >= CW'(DEPTH));
    assign sum  = {1'b0, r_total} + (TOTAL_W+1)'(r_cell_amt[0]);

    always_comb begin
        n_held    = r_held;
        n_open    = r_open;
        n_total   = r_total;
        n_status  = ST_DONE;
        n_srv_id  = '0;
        n_srv_amt = '0;
        enq_do    = 1'b0;
        deq_do    = 1'b0;
        unique case (r_kind)
            KIND_ENQ: begin
                if (!r_open)   n_status = ST_CLOSED;
                else if (full) n_status = ST_FULL;
                else begin
                    enq_do = 1'b1;
                    n_held = r_held + CW'(1);
                end
            end
            KIND_DEQ: begin
                if (!r_open)              n_status = ST_CLOSED;
                else if (r_held == '0)    n_status = ST_EMPTY;
                else begin
                    deq_do    = 1'b1;
                    n_held    = r_held - CW'(1);
                    n_srv_id  = r_cell_id[0];
                    n_srv_amt = r_cell_amt[0];
                    n_total   = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
                end
            end
            KIND_CLOSE: n_open = 1'b0;
            KIND_OPEN:  n_open = 1'b1;
            KIND_CLEAR: n_held = '0;
            default: ;
        endcase
    end

    // every cell compares its priority with the new one at once; the held
    // cells that keep their place form a prefix of the chain
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic prev_ge;
            logic [ID_W-1:0]          up_id;
            logic [AMT_W-1:0]         up_amt;
            logic signed [PRIO_W-1:0] up_prio;
            logic [ID_W-1:0]          dn_id;
            logic [AMT_W-1:0]         dn_amt;
            logic signed [PRIO_W-1:0] dn_prio;

            assign ge[k] = (CW'(k) < r_held) && (r_cell_prio[k] >= r_prio_in);

            if (k == 0) begin : g_head
                assign prev_ge = 1'b0;
                assign up_id   = r_id_in;
                assign up_amt  = r_amt_in;
                assign up_prio = r_prio_in;
            end else begin : g_body
                assign prev_ge = ge[k-1];
                assign up_id   = r_cell_id[k-1];
                assign up_amt  = r_cell_amt[k-1];
                assign up_prio = r_cell_prio[k-1];
            end

            if (k == DEPTH - 1) begin : g_tail
                assign dn_id   = r_cell_id[k];
                assign dn_amt  = r_cell_amt[k];
                assign dn_prio = r_cell_prio[k];
            end else begin : g_inner
                assign dn_id   = r_cell_id[k+1];
                assign dn_amt  = r_cell_amt[k+1];
                assign dn_prio = r_cell_prio[k+1];
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.exec && enq_do && !ge[k]) begin
                    if (k == 0 || prev_ge) begin
                        r_cell_id[k]   <= r_id_in;
                        r_cell_amt[k]  <= r_amt_in;
                        r_cell_prio[k] <= r_prio_in;
                    end else begin
                        r_cell_id[k]   <= up_id;
                        r_cell_amt[k]  <= up_amt;
                        r_cell_prio[k] <= up_prio;
                    end
                end else if (i_cmd.exec && deq_do) begin
                    r_cell_id[k]   <= dn_id;
                    r_cell_amt[k]  <= dn_amt;
                    r_cell_prio[k] <= dn_prio;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_id_in   <= i_customer_id;
            r_amt_in  <= i_amount_cents;
            r_prio_in <= i_priority_req;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_srv_id  <= n_srv_id;
            r_srv_amt <= n_srv_amt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_open  <= 1'b1;
            r_total <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_held  <= n_held;
                r_open  <= n_open;
                r_total <= n_total;
            end
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
        end
    end

    assign o_status        = r_status;
    assign o_served_id     = r_srv_id;
    assign o_served_amount = r_srv_amt;
    assign o_running_total = r_total;
    assign o_entry_count   = COUNT_W'(r_held);
    assign o_is_open       = r_open;

endmodule

// ===== rtl/bounded_stable_priority_queue.sv =====
// Top level of the bounded stable priority queue.
// Instantiates bsq_ctrl and bsq_datapath; depends on bsq_pkg.
//
// Usage:
//   Each input transaction on the s_axis channel carries one operation in
//   s_axis_tuser (enqueue, dequeue, close, open, clear) and the entry fields
//   in s_axis_tdata. Every transaction yields exactly one result transaction
//   on m_axis: the status code in m_axis_tuser, and the served entry, the
//   saturating running total, the entry count and the open flag in tdata.
//   Entries sit in a chain of DEPTH cells in descending priority; all cells
//   compare their priority with the new one in the same cycle, so enqueue
//   and dequeue each complete in the execute state whatever the fill level.
// Sequencing:
//   A result becomes valid once its operation has executed: after the
//   accepting edge the execute state runs the operation and loads the result
//   register as soon as the result slot is free. The controller takes a new
//   transaction only once the previous one has executed.
// Reset (i_rst_n low, synchronous): queue empty, open, total zero, capacity
//   limit 16, no result pending. Cell contents are not cleared.
// Stall: while m_axis_tready is low a pending result holds; the next input
//   is still captured, but its execution waits until the result is taken.
// Configuration: i_cfg_wr_en writes the capacity limit; write only when idle.
module bounded_stable_priority_queue
    import bsq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: customer_id[15:0], amount_cents[47:16], priority_req[63:48]
    input  logic [63:0]         s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [KIND_W-1:0]   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: served_id[15:0], served_amount[47:16], running_total[95:48],
    //        entry_count[100:96], is_open[101], zero[103:102]
    output logic [103:0]        m_axis_tdata,
    // tuser: status[1:0]
    output logic [STATUS_W-1:0] m_axis_tuser,
    input  logic                i_cfg_wr_en,
    input  logic [CAP_W-1:0]    i_cfg_wr_data
);

    t_ctl_cmd            cmd;
    logic [ID_W-1:0]     served_id;
    logic [AMT_W-1:0]    served_amount;
    logic [TOTAL_W-1:0]  running_total;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_open;

    // handshake sequencing: capture, then execute when the result slot frees
    bsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // cell chain, counters and result register
    bsq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (s_axis_tuser),
        .i_customer_id   (s_axis_tdata[15:0]),
        .i_amount_cents  (s_axis_tdata[47:16]),
        .i_priority_req  (s_axis_tdata[63:48]),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_status        (m_axis_tuser),
        .o_served_id     (served_id),
        .o_served_amount (served_amount),
        .o_running_total (running_total),
        .o_entry_count   (entry_count),
        .o_is_open       (is_open)
    );

    // pack the result fields, lowest field first, padded to whole bytes
    assign m_axis_tdata = {2'b00, is_open, entry_count, running_total,
                           served_amount, served_id};

endmodule

// ===== test/bounded_stable_priority_queue_tb.sv =====
// Self-checking testbench for bounded_stable_priority_queue.
// Predicts every result with its own queue model and checks it field by field.
// Depends on bsq_pkg and the RTL under rtl/.
module bounded_stable_priority_queue_tb
    import bsq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    localparam int CYCLE_LIMIT  = 100_000;

    // kinds the block decodes as no operation
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     served_id;
        logic [AMT_W-1:0]    served_amount;
        logic [TOTAL_W-1:0]  total;
        logic [COUNT_W-1:0]  count;
        logic                is_open;
    } t_queue_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata;
    logic [KIND_W-1:0]   s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [103:0]        m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                i_cfg_wr_en;
    logic [CAP_W-1:0]    i_cfg_wr_data;

    // queue model: entries in service order, head at index 0
    logic [ID_W-1:0]          mdl_id   [QUEUE_DEPTH];
    logic [AMT_W-1:0]         mdl_amt  [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] mdl_prio [QUEUE_DEPTH];
    int                       mdl_count;
    logic                     mdl_open;
    logic [TOTAL_W:0]         mdl_total;  // one spare bit to detect overflow
    logic [CAP_W-1:0]         mdl_cap;

    t_queue_result pending_results[$];

    bit sender_gaps_on;
    bit receiver_stalls_on;
    int mismatch_count;
    int results_checked;
    int ops_sent;
    int cycle_count;

    bounded_stable_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Queue model: apply one operation, return the result it must produce
    // ------------------------------------------------------------------
    function automatic t_queue_result predict_queue_op(input logic [KIND_W-1:0] kind,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [AMT_W-1:0] amt,
                                                      input logic signed [PRIO_W-1:0] prio);
        t_queue_result r;
        int room;
        int pos;
        r.status        = ST_DONE;
        r.served_id     = '0;
        r.served_amount = '0;
        // a capacity above the depth acts as the depth
        room = (int'(mdl_cap) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(mdl_cap);
        case (kind)
            KIND_ENQ: begin
                if (!mdl_open) begin
                    r.status = ST_CLOSED;
                end else if (mdl_count >= room) begin
                    r.status = ST_FULL;
                end else begin
                    // go behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < mdl_count && mdl_prio[pos] >= prio) pos++;
                    for (int k = mdl_count; k > pos; k--) begin
                        mdl_id[k]   = mdl_id[k-1];
                        mdl_amt[k]  = mdl_amt[k-1];
                        mdl_prio[k] = mdl_prio[k-1];
                    end
                    mdl_id[pos]   = id;
                    mdl_amt[pos]  = amt;
                    mdl_prio[pos] = prio;
                    mdl_count++;
                end
            end
            KIND_DEQ: begin
                if (!mdl_open) begin
                    r.status = ST_CLOSED;
                end else if (mdl_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.served_id     = mdl_id[0];
                    r.served_amount = mdl_amt[0];
                    mdl_total = mdl_total + {{(TOTAL_W+1-AMT_W){1'b0}}, mdl_amt[0]};
                    if (mdl_total > {1'b0, TOTAL_MAX}) mdl_total = {1'b0, TOTAL_MAX};
                    for (int k = 1; k < mdl_count; k++) begin
                        mdl_id[k-1]   = mdl_id[k];
                        mdl_amt[k-1]  = mdl_amt[k];
                        mdl_prio[k-1] = mdl_prio[k];
                    end
                    mdl_count--;
                end
            end
            KIND_CLOSE: mdl_open = 1'b0;
            KIND_OPEN:  mdl_open = 1'b1;
            KIND_CLEAR: mdl_count = 0;   // total and open flag stay
            default: ;
        endcase
        r.total   = mdl_total[TOTAL_W-1:0];
        r.count   = COUNT_W'(mdl_count);
        r.is_open = mdl_open;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Drive one operation and wait for its transaction. Leave tvalid high on
    // exit so that a back-to-back operation never drops it for a step.
    task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                            input logic [AMT_W-1:0] amt, input logic [PRIO_W-1:0] prio);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {prio, amt, id};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.insert(pending_results.size(), predict_queue_op(kind, id, amt, prio));
        ops_sent++;
    endtask

    // Hold the sender off until every predicted result has been taken.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the capacity limit once the block has nothing in flight.
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        wait_results_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mdl_cap = value;
    endtask

    function automatic logic [PRIO_W-1:0] random_priority();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return PRIO_W'($urandom_range(0, 4) - 2);  // crowd ties
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        return ID_W'($urandom);
    endfunction

    function automatic logic [AMT_W-1:0] random_amount();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return AMT_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: stall tready per result and check each transaction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    initial begin : result_monitor
        int            stall_left;
        logic          next_ready;
        t_queue_result want;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (m_axis_tvalid && m_axis_tready) begin
                    results_checked++;
                    if (pending_results.size() == 0) begin
                        mismatch_count++;
                        $display("%0t: unexpected result, expected none, %s %0h %0h",
                                 $time, "actual tuser and tdata", m_axis_tuser,
                                 m_axis_tdata);
                    end else begin
                        want = pending_results[0];
                        pending_results.delete(0);
                        check_field("status", 64'(want.status), 64'(m_axis_tuser));
                        check_field("served_id", 64'(want.served_id),
                                    64'(m_axis_tdata[15:0]));
                        check_field("served_amount", 64'(want.served_amount),
                                    64'(m_axis_tdata[47:16]));
                        check_field("running_total", 64'(want.total),
                                    64'(m_axis_tdata[95:48]));
                        check_field("entry_count", 64'(want.count),
                                    64'(m_axis_tdata[100:96]));
                        check_field("is_open", 64'(want.is_open),
                                    64'(m_axis_tdata[101]));
                        check_field("tdata padding", 64'(0),
                                    64'(m_axis_tdata[103:102]));
                    end
                    stall_left = receiver_stalls_on ? $urandom_range(0, 9) : 0;
                end
                if (stall_left > 0) begin
                    stall_left--;
                    next_ready = 1'b0;
                end else begin
                    next_ready = 1'b1;
                end
                m_axis_tready <= next_ready;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Priority order, ties first-in first-out, field extremes, empty refusal.
    task automatic test_service_order();
        issue_op(KIND_DEQ, 16'h5A5A, 32'h1, 16'h0);              // empty queue
        issue_op(KIND_ENQ, 16'h0000, 32'h0000_0000, 16'h0000);
        issue_op(KIND_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 16'h7FFF);
        issue_op(KIND_ENQ, 16'h1234, 32'h0000_0001, 16'h8000);
        issue_op(KIND_ENQ, 16'h0001, 32'd100, 16'h0000);         // tie, goes behind
        issue_op(KIND_ENQ, 16'h0002, 32'd200, 16'h0000);
        repeat (6) issue_op(KIND_DEQ, random_id(), random_amount(), random_priority());
    endtask

    // A closed queue refuses enqueue and dequeue; clear still empties it.
    task automatic test_closed_queue();
        issue_op(KIND_ENQ, random_id(), random_amount(), random_priority());
        issue_op(KIND_ENQ, random_id(), random_amount(), random_priority());
        issue_op(KIND_CLOSE, random_id(), random_amount(), random_priority());
        issue_op(KIND_ENQ, random_id(), random_amount(), random_priority());
        issue_op(KIND_DEQ, random_id(), random_amount(), random_priority());
        issue_op(KIND_CLEAR, random_id(), random_amount(), random_priority());
        issue_op(KIND_SPARE_A, random_id(), random_amount(), random_priority());
        issue_op(KIND_SPARE_C, random_id(), random_amount(), random_priority());
        issue_op(KIND_OPEN, random_id(), random_amount(), random_priority());
        issue_op(KIND_DEQ, random_id(), random_amount(), random_priority());
    endtask

    // Zero capacity refuses every enqueue; capacity one holds a single entry.
    task automatic test_capacity_edges();
        set_capacity(5'd0);
        issue_op(KIND_ENQ, random_id(), random_amount(), random_priority());
        set_capacity(5'd1);
        issue_op(KIND_ENQ, random_id(), random_amount(), random_priority());
        issue_op(KIND_ENQ, random_id(), random_amount(), random_priority());
        issue_op(KIND_DEQ, random_id(), random_amount(), random_priority());
    endtask

    // Mostly well-formed enqueue/dequeue traffic with some control noise.
    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int n_ops,
                                    input int enq_weight, input bit idling);
        int                roll;
        logic [KIND_W-1:0] kind;
        set_capacity(cap);
        sender_gaps_on     = idling;
        receiver_stalls_on = idling;
        for (int i = 0; i < n_ops; i++) begin
            // hold off mid-phase until the block has answered everything
            if (i == n_ops / 2) wait_results_drained();
            roll = $urandom_range(0, 99);
            if (!mdl_open && roll < 50)  kind = KIND_OPEN;
            else if (roll < enq_weight)  kind = KIND_ENQ;
            else if (roll < 94)          kind = KIND_DEQ;
            else if (roll < 96)          kind = KIND_CLOSE;
            else if (roll < 97)          kind = KIND_OPEN;
            else if (roll < 99)          kind = KIND_CLEAR;
            else begin
                case ($urandom_range(0, 2))
                    0:       kind = KIND_SPARE_A;
                    1:       kind = KIND_SPARE_B;
                    default: kind = KIND_SPARE_C;
                endcase
            end
            issue_op(kind, random_id(), random_amount(), random_priority());
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(5'd16, 110, 70, 1'b1);
        run_random_phase(5'd31, 110, 75, 1'b1);   // capacity above the depth
        run_random_phase(5'd3, 110, 55, 1'b1);
        run_random_phase(5'd0, 60, 40, 1'b1);
        run_random_phase(CAP_W'($urandom_range(1, 31)), 110, 50, 1'b1);
        run_random_phase(5'd16, 120, 50, 1'b0);   // back-to-back, no stalls
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_ENQ;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        mismatch_count     = 0;
        results_checked    = 0;
        ops_sent           = 0;
        mdl_count = 0;
        mdl_open  = 1'b1;
        mdl_total = '0;
        mdl_cap   = CAP_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_service_order();
        test_closed_queue();
        test_capacity_edges();
        test_random_traffic();

        // drain, then leave room for any stray result to show up
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d operations, checked %0d results: ordering, ties, closed queue,",
                 ops_sent, results_checked);
        $display("capacity 0 to 31, clears, spare kinds and random traffic with stalls.");
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== bounded_stable_priority_queue.f =====
rtl/bsq_pkg.sv
rtl/bsq_ctrl.sv
rtl/bsq_datapath.sv
rtl/bounded_stable_priority_queue.sv
test/bounded_stable_priority_queue_tb.sv
